// ----- rtl/core/mbb_pkg.sv -----
// Shared types and constants of the 1-bpp bitmap blitter.
// Used by mono_bitmap_blitter_top; depends on nothing else.
package mbb_pkg;

	// Sizes and limits of the source bitmap and of the block scale.
	localparam logic [10:0] MAX_WIDTH = 11'd1024;
	localparam logic [3:0]  MAX_SCALE = 4'd8;
	localparam logic [10:0] ROW_LIMIT = 11'd2047;

	// Configuration register indexes.
	localparam logic [2:0] REG_BITMAP_WIDTH = 3'd0;
	localparam logic [2:0] REG_REGION_X     = 3'd1;
	localparam logic [2:0] REG_REGION_Y     = 3'd2;
	localparam logic [2:0] REG_REGION_W     = 3'd3;
	localparam logic [2:0] REG_REGION_H     = 3'd4;
	localparam logic [2:0] REG_DEST_X       = 3'd5;
	localparam logic [2:0] REG_DEST_Y       = 3'd6;
	localparam logic [2:0] REG_DRAW_MODE    = 3'd7;

	// Bit positions in draw_mode.
	localparam int MODE_TRANSP_EN  = 12;
	localparam int MODE_TRANSP_VAL = 13;
	localparam int MODE_INVERT     = 14;

	// One source bit.
	typedef struct packed {
		logic pixel_bit;
		logic end_of_image;
	} in_t;

	// One pixel write.
	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [7:0]         pixel_color;
		logic               run_end;
	} out_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

endpackage

// ----- rtl/core/mono_bitmap_blitter_top.sv -----
// Top level of the 1-bpp bitmap blitter: column/row tracking, clipping and
// the pixel-write sequencer. Depends on mbb_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------
//  in       | input     | in_valid / in_stall  | in_data  (pixel bit, end)
//  out      | output    | out_valid / out_stall| out_data (x, y, color)
//  cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// A bit that draws nothing is only accepted; a drawn bit is accepted, then
// expands into scale*scale pixel writes, one pixel write per cycle while the
// output does not stall, since x/y stepping adders under the sequencer make
// the writes in order. in_stall is high while the sequencer emits; stalls on
// the output hold the output register and the sequencer. Reset clears the
// counters and out_valid and presets the configuration; no clearing pass.
module mono_bitmap_blitter_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  mbb_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output mbb_pkg::out_t out_data,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import mbb_pkg::*;

	// Configuration registers.
	logic [10:0] bitmap_width_q;
	logic [9:0]  region_x_q;
	logic [9:0]  region_y_q;
	logic [10:0] region_w_q;
	logic [10:0] region_h_q;
	logic [15:0] dest_x_q;
	logic [15:0] dest_y_q;
	logic [14:0] draw_mode_q;

	// Position in the source stream.
	logic [10:0] col_q;
	logic [10:0] row_q;

	// Sequencer and stepping state.
	state_t      state_q;
	logic [15:0] cur_x_q;
	logic [15:0] cur_y_q;
	logic [15:0] x0_q;
	logic [2:0]  dx_q;
	logic [2:0]  dy_q;
	logic [2:0]  scale_m1_q;

	// Output register.
	logic        out_valid_q;
	out_t        out_q;

	// Combinational signals.
	logic        in_xfer;
	logic [10:0] w_eff;
	logic [10:0] col_off;
	logic [10:0] row_off;
	logic        in_region;
	logic        pix;
	logic        dropped;
	logic        draw;
	logic [3:0]  scale_raw;
	logic [3:0]  scale;
	logic [13:0] prod_x;
	logic [13:0] prod_y;
	logic [8:0]  bytes_raw;
	logic [8:0]  bytes;
	logic [11:0] padded;
	logic [11:0] col_next;
	logic        emit_load;
	logic        dx_last;
	logic        dy_last;

	assign in_xfer   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Clip the current source position against the bitmap and the region.
	always_comb begin
		w_eff   = (bitmap_width_q > MAX_WIDTH) ? MAX_WIDTH : bitmap_width_q;
		col_off = col_q - {1'b0, region_x_q};
		row_off = row_q - {1'b0, region_y_q};
		in_region = (col_q < w_eff) &&
			(col_q >= {1'b0, region_x_q}) && (col_off < region_w_q) &&
			(row_q >= {1'b0, region_y_q}) && (row_off < region_h_q);
		pix     = in_data.pixel_bit ^ draw_mode_q[MODE_INVERT];
		dropped = draw_mode_q[MODE_TRANSP_EN] && (pix == draw_mode_q[MODE_TRANSP_VAL]);
		draw    = in_region && !dropped && pix;
	end

	// Saturated scale and the scaled offset of the region pixel.
	always_comb begin
		scale_raw = draw_mode_q[11:8];
		if (scale_raw == 4'd0) begin
			scale = 4'd1;
		end else if (scale_raw > MAX_SCALE) begin
			scale = MAX_SCALE;
		end else begin
			scale = scale_raw;
		end
		prod_x = col_off[9:0] * scale;
		prod_y = row_off * scale;
	end

	// Row length in bits, padded to whole bytes, at least one byte.
	always_comb begin
		bytes_raw = 9'((12'(w_eff) + 12'd7) >> 3);
		bytes     = (bytes_raw == 9'd0) ? 9'd1 : bytes_raw;
		padded    = {bytes, 3'b000};
		col_next  = {1'b0, col_q} + 12'd1;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_width_q <= 11'd1;
			region_x_q     <= '0;
			region_y_q     <= '0;
			region_w_q     <= '0;
			region_h_q     <= '0;
			dest_x_q       <= '0;
			dest_y_q       <= '0;
			draw_mode_q    <= 15'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BITMAP_WIDTH: bitmap_width_q <= cfg_data[10:0];
				REG_REGION_X:     region_x_q     <= cfg_data[9:0];
				REG_REGION_Y:     region_y_q     <= cfg_data[9:0];
				REG_REGION_W:     region_w_q     <= cfg_data[10:0];
				REG_REGION_H:     region_h_q     <= cfg_data[10:0];
				REG_DEST_X:       dest_x_q       <= cfg_data;
				REG_DEST_Y:       dest_y_q       <= cfg_data;
				REG_DRAW_MODE:    draw_mode_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Column and row tracking on every accepted source bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (in_data.end_of_image) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_next >= padded) begin
				col_q <= '0;
				if (row_q < ROW_LIMIT) begin
					row_q <= row_q + 11'd1;
				end
			end else begin
				col_q <= col_next[10:0];
			end
		end
	end

	// The output register takes a new write when it is empty or draining.
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign dx_last   = (dx_q == scale_m1_q);
	assign dy_last   = (dy_q == scale_m1_q);

	// Sequencer: load the block origin, then step x inside y.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dx_q       <= '0;
			dy_q       <= '0;
			scale_m1_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && draw) begin
						state_q    <= ST_EMIT;
						dx_q       <= '0;
						dy_q       <= '0;
						scale_m1_q <= 3'(scale - 4'd1);
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (dx_last) begin
							dx_q <= '0;
							dy_q <= dy_q + 3'd1;
							if (dy_last) begin
								state_q <= ST_IDLE;
							end
						end else begin
							dx_q <= dx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Destination coordinates of the next write.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer && draw) begin
			cur_x_q <= dest_x_q + {2'b00, prod_x};
			x0_q    <= dest_x_q + {2'b00, prod_x};
			cur_y_q <= dest_y_q + {2'b00, prod_y};
		end else if (emit_load) begin
			if (dx_last) begin
				cur_x_q <= x0_q;
				cur_y_q <= cur_y_q + 16'd1;
			end else begin
				cur_x_q <= cur_x_q + 16'd1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q.pixel_x     <= cur_x_q;
			out_q.pixel_y     <= cur_y_q;
			out_q.pixel_color <= draw_mode_q[7:0];
			out_q.run_end     <= dx_last && dy_last;
		end
	end

	// The sequencer state is always a single one-hot code.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state is not one-hot");

	// Step counters stay inside the latched block size while emitting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dx_q <= scale_m1_q && dy_q <= scale_m1_q))
		else $error("step counter beyond block size");

	// The row counter saturates instead of wrapping.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !in_data.end_of_image && row_q == ROW_LIMIT) |=> (row_q == ROW_LIMIT))
		else $error("row counter wrapped");

	// The last write of a block hands control back to the idle state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && dx_last && dy_last) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("sequencer did not finish after the last write");

endmodule
